// ===== rtl/core/tslb_pkg.sv =====
// tslb_pkg: types and constants shared by the table search block
// used by tslb_ram, table_search_linear_binary_top and tslb_checker
`timescale 1ns / 1ps

package tslb_pkg;

	localparam int ENTRY_W    = 32;
	localparam int ADDR_W     = 10;
	localparam int POS_W      = 10;
	localparam int CMP_W      = 11;
	localparam int SIZE_W     = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 1'b1;

	localparam logic MODE_LINEAR = 1'b0;
	localparam logic MODE_BINARY = 1'b1;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 11'd1;

	typedef struct packed {
		logic                      op;
		logic [ADDR_W-1:0]         entry_addr;
		logic signed [ENTRY_W-1:0] entry_value;
		logic signed [ENTRY_W-1:0] search_key;
	} tslb_in_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [CMP_W-1:0] comparisons;
	} tslb_out_t;

endpackage

// ===== rtl/core/tslb_ram.sv =====
// tslb_ram: table memory with one write port and one read port, registered read
// depends on tslb_pkg for the entry width
`timescale 1ns / 1ps

module tslb_ram
	import tslb_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/table_search_linear_binary_top.sv =====
// table_search_linear_binary_top: table of signed entries with linear and binary search
// depends on tslb_pkg and tslb_ram
`timescale 1ns / 1ps
//
// Usage:
//   cmd is taken when start is high and busy is low. A load (op = load) writes
//   entry_value at entry_addr in that same cycle, gives no result and leaves
//   busy low, so loads can be issued every cycle. Loads beyond the depth are dropped.
//   A search of a nonempty table raises busy until its result. The result shows on result for one
//   cycle with done high; busy falls in that same cycle, so a new command can be
//   taken while the result is shown. The receiver cannot stall.
//   Linear mode: one table read per cycle through the memory port, pipelined;
//   each entry is compared with the key in index order up to the first hit or the last entry.
//   Binary mode: each step is a memory read (S_BIN_RD) and a compare (S_BIN_CMP);
//   a miss is reported from S_BIN_RD once the search range is empty.
//   A search over an empty table gives done in the cycle after the transfer.
//   cfg_we writes table_size or search_mode at once; write only when idle.
//   Reset clears control state and sets table_size to 1 and search_mode to linear;
//   table contents stay undefined until loaded.
//

module table_search_linear_binary_top
	import tslb_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  tslb_in_t              cmd,
	output logic                  done,
	output tslb_out_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = (CW > SIZE_W) ? CW : SIZE_W;
	localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LIN,
		S_BIN_RD,
		S_BIN_CMP
	} state_t;

	state_t            state_q;
	logic              busy_q;
	logic              done_q;
	tslb_out_t         result_q;
	logic [SIZE_W-1:0] table_size_q;
	logic              search_mode_q;
	logic signed [ENTRY_W-1:0] key_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     rd_idx_q;
	logic              cmp_vld_s1;
	logic [AW-1:0]     cmp_idx_s1;
	logic [NW-1:0]     first_q;
	logic [NW-1:0]     hi_q;
	logic [AW-1:0]     mid_q;
	logic [NW-1:0]     cnt_q;

	logic              accept;
	logic [NW-1:0]     n_sat;
	logic [NW:0]       mid_sum;
	logic [AW-1:0]     mid;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic signed [ENTRY_W-1:0] entry;
	logic [NW-1:0]     lin_comps;

	assign accept = start && !busy_q;
	assign n_sat  = (NW'(table_size_q) > DEPTH_N) ? DEPTH_N : NW'(table_size_q);

	// truncating midpoint of [first, hi - 1]
	assign mid_sum = {1'b0, first_q} + {1'b0, hi_q} - (NW+1)'(1);
	assign mid     = mid_sum[AW:1];

	assign ram_we    = accept && (cmd.op == OP_LOAD) && (NW'(cmd.entry_addr) < DEPTH_N);
	assign ram_waddr = AW'(cmd.entry_addr);
	assign ram_re    = ((state_q == S_LIN) && (rd_idx_q < n_q)) ||
	                   ((state_q == S_BIN_RD) && (first_q < hi_q));
	assign ram_raddr = (state_q == S_LIN) ? rd_idx_q[AW-1:0] : mid;

	assign entry     = $signed(ram_rdata);
	assign lin_comps = NW'(cmp_idx_s1) + NW'(1);

	tslb_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.entry_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q  <= TABLE_SIZE_RESET;
			search_mode_q <= MODE_LINEAR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_SIZE:  table_size_q  <= SIZE_W'(cfg_wdata);
				REG_SEARCH_MODE: search_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			busy_q     <= 1'b0;
			done_q     <= 1'b0;
			result_q   <= '0;
			key_q      <= '0;
			n_q        <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			first_q    <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			cnt_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (cmd.op == OP_SEARCH)) begin
						key_q      <= cmd.search_key;
						n_q        <= n_sat;
						rd_idx_q   <= '0;
						cmp_vld_s1 <= 1'b0;
						first_q    <= '0;
						hi_q       <= n_sat;
						cnt_q      <= '0;
						if (n_sat == '0) begin
							// empty table
							done_q   <= 1'b1;
							result_q <= '0;
						end else begin
							busy_q  <= 1'b1;
							state_q <= (search_mode_q == MODE_BINARY) ? S_BIN_RD : S_LIN;
						end
					end
				end
				S_LIN: begin
					if (ram_re) begin
						rd_idx_q   <= rd_idx_q + NW'(1);
						cmp_idx_s1 <= rd_idx_q[AW-1:0];
					end
					cmp_vld_s1 <= ram_re;
					if (cmp_vld_s1) begin
						if (entry == key_q) begin
							done_q               <= 1'b1;
							busy_q               <= 1'b0;
							result_q.found       <= 1'b1;
							result_q.position    <= POS_W'(cmp_idx_s1);
							result_q.comparisons <= CMP_W'(lin_comps);
							state_q              <= S_IDLE;
						end else if (lin_comps == n_q) begin
							done_q               <= 1'b1;
							busy_q               <= 1'b0;
							result_q.found       <= 1'b0;
							result_q.position    <= '0;
							result_q.comparisons <= CMP_W'(n_q);
							state_q              <= S_IDLE;
						end
					end
				end
				S_BIN_RD: begin
					if (first_q < hi_q) begin
						mid_q   <= mid;
						cnt_q   <= cnt_q + NW'(1);
						state_q <= S_BIN_CMP;
					end else begin
						done_q               <= 1'b1;
						busy_q               <= 1'b0;
						result_q.found       <= 1'b0;
						result_q.position    <= '0;
						result_q.comparisons <= CMP_W'(cnt_q);
						state_q              <= S_IDLE;
					end
				end
				S_BIN_CMP: begin
					if (entry == key_q) begin
						done_q               <= 1'b1;
						busy_q               <= 1'b0;
						result_q.found       <= 1'b1;
						result_q.position    <= POS_W'(mid_q);
						result_q.comparisons <= CMP_W'(cnt_q);
						state_q              <= S_IDLE;
					end else begin
						if (entry > key_q) begin
							hi_q <= NW'(mid_q);
						end else begin
							first_q <= NW'(mid_q) + NW'(1);
						end
						state_q <= S_BIN_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/core/tslb_checker.sv =====
// tslb_checker: port-level assertions for the table search block
// depends on tslb_pkg; bound to table_search_linear_binary_top
`timescale 1ns / 1ps

module tslb_checker
	import tslb_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input tslb_in_t  cmd,
	input logic      done,
	input tslb_out_t result
);

	// result shows only once the search has released the block
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a miss reports position zero
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.position == '0))
		else $error("miss with nonzero position");

	// a hit took at least one comparison
	a_hit_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found) |-> (result.comparisons != '0))
		else $error("hit with zero comparisons");

	// a load transfer gives no result and does not occupy the block
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd.op == OP_LOAD)) |=> (!busy && !done))
		else $error("load caused busy or result");

	// busy only rises after a search transfer
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ($past(start) && (!$past(busy)) && ($past(cmd.op) == OP_SEARCH)))
		else $error("busy rose without search transfer");

endmodule

bind table_search_linear_binary_top tslb_checker u_tslb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for table_search_linear_binary_top, load and search transfers
// predicts each search result from a local copy of the table and registers
// depends on tslb_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;
	import tslb_pkg::*;

	localparam int TABLE_DEPTH    = 1024;
	localparam int RANDOM_ITEMS   = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 64;
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int MAX_REPORTS    = 40;

	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = 32'sh8000_0000;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 32'sh7FFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	tslb_in_t              cmd;
	logic                  done;
	tslb_out_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	logic signed [ENTRY_W-1:0] entries [TABLE_DEPTH];
	logic [SIZE_W-1:0]         cur_size;
	logic                      cur_mode;
	tslb_out_t                 pending_results [$];
	tslb_out_t                 want_result;
	int                        errors = 0;
	int                        items_sent = 0;
	int                        quiet_cycles = 0;
	bit                        idle_on = 1'b0;
	bit                        start_high = 1'b0;

	table_search_linear_binary_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tslb_out_t search_table(logic signed [ENTRY_W-1:0] key);
		tslb_out_t r;
		int n;
		int lo;
		int hi;
		int mid;
		int i;
		r = '0;
		n = (cur_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_size);
		if (cur_mode == MODE_LINEAR) begin
			for (i = 0; i < n; i++) begin
				r.comparisons = r.comparisons + CMP_W'(1);
				if (entries[i] == key) begin
					r.found = 1'b1;
					r.position = POS_W'(i);
					return r;
				end
			end
		end else begin
			lo = 0;
			hi = n - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				r.comparisons = r.comparisons + CMP_W'(1);
				if (entries[mid] == key) begin
					r.found = 1'b1;
					r.position = POS_W'(mid);
					return r;
				end
				if (entries[mid] > key)
					hi = mid - 1;
				else
					lo = mid + 1;
			end
		end
		return r;
	endfunction

	task automatic lower_start;
		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
	endtask

	task automatic send_item(tslb_in_t item);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			lower_start();
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		start <= 1'b1;
		start_high = 1'b1;
		cmd <= item;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (item.op == OP_LOAD)
			entries[item.entry_addr] = item.entry_value;
		else
			pending_results.push_back(search_table(item.search_key));
		items_sent++;
	endtask

	task automatic load_entry(int addr, logic signed [ENTRY_W-1:0] value);
		tslb_in_t item;
		item.op = OP_LOAD;
		item.entry_addr = ADDR_W'(addr);
		item.entry_value = value;
		item.search_key = $urandom;
		send_item(item);
	endtask

	task automatic search_for(logic signed [ENTRY_W-1:0] key);
		tslb_in_t item;
		item.op = OP_SEARCH;
		item.entry_addr = ADDR_W'($urandom_range(0, TABLE_DEPTH - 1));
		item.entry_value = $urandom;
		item.search_key = key;
		send_item(item);
	endtask

	// hold off until every search has answered and the block is idle
	task automatic drain;
		lower_start();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [SIZE_W-1:0] size, logic mode);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_TABLE_SIZE;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_index <= REG_SEARCH_MODE;
		cfg_wdata <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_size = size;
		cur_mode = mode;
	endtask

	task automatic test_reset_defaults;
		load_entry(0, 42);
		search_for(42);
		search_for(43);
	endtask

	task automatic test_linear_scan;
		load_entry(0, ENTRY_MIN);
		load_entry(1, ENTRY_MAX);
		load_entry(2, 0);
		load_entry(3, -1);
		load_entry(4, 0);
		load_entry(5, 12345);
		set_config(11'd6, MODE_LINEAR);
		search_for(ENTRY_MIN);
		search_for(-1);
		search_for(0);
		search_for(12345);
		search_for(ENTRY_MAX);
		search_for(7);
		set_config(11'd0, MODE_LINEAR);
		search_for(ENTRY_MIN);
	endtask

	task automatic test_binary_search;
		load_entry(0, ENTRY_MIN);
		load_entry(1, -1000);
		load_entry(2, -1);
		load_entry(3, 0);
		load_entry(4, 1);
		load_entry(5, 1000);
		load_entry(6, ENTRY_MAX);
		set_config(11'd7, MODE_BINARY);
		search_for(ENTRY_MIN);
		search_for(0);
		search_for(ENTRY_MAX);
		search_for(1000);
		search_for(-500);
		search_for(500);
		set_config(11'd1, MODE_BINARY);
		search_for(ENTRY_MIN);
		search_for(0);
		set_config(11'd0, MODE_BINARY);
		search_for(0);
	endtask

	// strictly ascending fill from the minimum to the maximum entry value
	task automatic test_full_table;
		int i;
		logic [ENTRY_W-1:0] value;
		for (i = 0; i < TABLE_DEPTH; i++) begin
			if (i == 0)
				value = ENTRY_MIN;
			else if (i == TABLE_DEPTH - 1)
				value = ENTRY_MAX;
			else
				value = (32'(i) << 22) + 32'($urandom_range(0, 2097151)) + 32'h8000_0000;
			load_entry(i, value);
		end
		set_config(11'd1024, MODE_BINARY);
		search_for(entries[0]);
		search_for(entries[TABLE_DEPTH - 1]);
		search_for(entries[511]);
		search_for(entries[700] + 1);
		set_config(11'd2047, MODE_BINARY);
		search_for(ENTRY_MAX);
		search_for(entries[3]);
		set_config(11'd1024, MODE_LINEAR);
		search_for(ENTRY_MAX);
		search_for(entries[5] + 1);
		set_config(11'd1025, MODE_LINEAR);
		search_for(entries[1000]);
	endtask

	task automatic test_random_rounds;
		int first;
		int n;
		int i;
		int j;
		int k;
		int tmp;
		int nsearch;
		int pick;
		int vals [$];
		logic [SIZE_W-1:0] size;
		logic mode;
		logic signed [ENTRY_W-1:0] pool [4];
		logic signed [ENTRY_W-1:0] key;
		first = items_sent;
		while (items_sent - first < RANDOM_ITEMS) begin
			idle_on = (items_sent - first < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 3)
				size = SIZE_W'($urandom_range(1025, 2047));
			else if (pick < 8)
				size = SIZE_W'($urandom_range(257, 1024));
			else if (pick < 20)
				size = SIZE_W'($urandom_range(33, 256));
			else if (pick < 23)
				size = '0;
			else
				size = SIZE_W'($urandom_range(1, 32));
			mode = ($urandom_range(0, 1) == 0) ? MODE_LINEAR : MODE_BINARY;
			set_config(size, mode);
			n = (size > TABLE_DEPTH) ? TABLE_DEPTH : int'(size);
			if (n <= 64) begin
				vals.delete();
				for (i = 0; i < 4; i++)
					pool[i] = $urandom;
				for (i = 0; i < n; i++) begin
					pick = $urandom_range(0, 3);
					if (pick == 0)
						vals.push_back(int'(pool[$urandom_range(0, 3)]));
					else if (pick == 1)
						vals.push_back(int'($urandom_range(0, 7)) - 4);
					else
						vals.push_back(int'($urandom));
				end
				if (mode == MODE_BINARY) begin
					vals.sort();
					// occasionally break the ordering
					if (n > 1 && $urandom_range(0, 7) == 0) begin
						j = $urandom_range(0, n - 1);
						k = $urandom_range(0, n - 1);
						tmp = vals[j];
						vals[j] = vals[k];
						vals[k] = tmp;
					end
				end
				for (i = 0; i < n; i++)
					load_entry(i, vals[i]);
			end
			nsearch = (n > 64) ? $urandom_range(1, 3) : $urandom_range(3, 12);
			for (i = 0; i < nsearch; i++) begin
				if ($urandom_range(0, 7) == 0)
					load_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom);
				pick = $urandom_range(0, 9);
				if (n > 0 && pick < 6)
					key = entries[$urandom_range(0, n - 1)];
				else if (n > 0 && pick < 7)
					key = entries[$urandom_range(0, n - 1)] + 1;
				else
					key = $urandom;
				search_for(key);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors = errors + 1;
				if (errors <= MAX_REPORTS)
					$display({"%0t: result with none expected, ",
						"actual found=%0d position=%0d comparisons=%0d"},
						$time, result.found, result.position, result.comparisons);
			end else begin
				want_result = pending_results.pop_front();
				if (result.found !== want_result.found ||
						result.position !== want_result.position ||
						result.comparisons !== want_result.comparisons) begin
					errors = errors + 1;
					if (errors <= MAX_REPORTS)
						$display({"%0t: expected found=%0d position=%0d comparisons=%0d, ",
							"actual found=%0d position=%0d comparisons=%0d"},
							$time, want_result.found, want_result.position,
							want_result.comparisons,
							result.found, result.position, result.comparisons);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cur_size = TABLE_SIZE_RESET;
		cur_mode = MODE_LINEAR;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_reset_defaults();
		test_linear_scan();
		test_binary_search();
		test_full_table();
		test_random_rounds();
		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
